FILE: rtl/wqh_pkg.sv
// Shared types, codes and sizes for the work queue with undo and history.
`default_nettype none
package wqh_pkg;

  localparam int WORD_W = 32;
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    REQ_ENQUEUE      = 3'd0,
    REQ_PROCESS      = 3'd1,
    REQ_UNDO         = 3'd2,
    REQ_CLEAR_HIST   = 3'd3,
    REQ_READ_PENDING = 3'd4,
    REQ_READ_HIST    = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [WORD_W-1:0] item_word;
    logic [IDX_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] result_word;
    logic [CNT_W-1:0]  pending_total;
    logic [CNT_W-1:0]  undo_total;
    logic [CNT_W-1:0]  history_total;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

endpackage
`default_nettype wire

FILE: rtl/wqh_store.sv
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module wqh_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/wqh_ctrl.sv
// Pointer and count registers plus the per-request decode for all three stores.
`default_nettype none
module wqh_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  input  wire wqh_pkg::req_t               req,
  input  wire wqh_pkg::req_t               req_in,
  input  wire logic [wqh_pkg::WORD_W-1:0]  pend_rd_data,
  input  wire logic [wqh_pkg::WORD_W-1:0]  undo_rd_data,
  input  wire logic [wqh_pkg::WORD_W-1:0]  hist_rd_data,
  output logic      [wqh_pkg::IDX_W-1:0]   pend_rd_addr,
  output logic      [wqh_pkg::IDX_W-1:0]   undo_rd_addr,
  output logic      [wqh_pkg::IDX_W-1:0]   hist_rd_addr,
  output wqh_pkg::store_wr_t               pend_wr,
  output wqh_pkg::store_wr_t               undo_wr,
  output wqh_pkg::store_wr_t               hist_wr,
  output wqh_pkg::res_t                    res
);

  localparam logic [wqh_pkg::IDX_W-1:0] IDX_ONE = wqh_pkg::IDX_W'(1);
  localparam logic [wqh_pkg::CNT_W-1:0] CNT_ONE = wqh_pkg::CNT_W'(1);

  logic [wqh_pkg::IDX_W-1:0] p_head, p_head_next;
  logic [wqh_pkg::CNT_W-1:0] p_count, p_count_next;
  logic [wqh_pkg::IDX_W-1:0] u_top, u_top_next;
  logic [wqh_pkg::CNT_W-1:0] u_count, u_count_next;
  logic [wqh_pkg::IDX_W-1:0] h_newest, h_newest_next;
  logic [wqh_pkg::CNT_W-1:0] h_count, h_count_next;

  logic [wqh_pkg::IDX_W-1:0]  p_tail;
  logic [wqh_pkg::CNT_W-1:0]  pos_ext;
  logic [1:0]                 status;
  logic [wqh_pkg::WORD_W-1:0] word;

  logic                       pend_byp, undo_byp, hist_byp;
  logic [wqh_pkg::WORD_W-1:0] pend_byp_data, undo_byp_data, hist_byp_data;
  logic [wqh_pkg::WORD_W-1:0] pend_word, undo_word, hist_word;

  // stores are read at the edge that registers the request, using the pointers
  // left by the request ahead of it; a write at that same edge is forwarded
  assign pend_word = pend_byp ? pend_byp_data : pend_rd_data;
  assign undo_word = undo_byp ? undo_byp_data : undo_rd_data;
  assign hist_word = hist_byp ? hist_byp_data : hist_rd_data;

  assign p_tail       = p_head + p_count[wqh_pkg::IDX_W-1:0];
  assign pos_ext      = {1'b0, req.position};
  assign pend_rd_addr = (req_in.req_type == wqh_pkg::REQ_PROCESS) ? p_head_next
                                                                  : p_head_next + req_in.position;
  assign undo_rd_addr = u_top_next;
  assign hist_rd_addr = h_newest_next - req_in.position;

  always_comb begin
    p_head_next   = p_head;
    p_count_next  = p_count;
    u_top_next    = u_top;
    u_count_next  = u_count;
    h_newest_next = h_newest;
    h_count_next  = h_count;
    status        = wqh_pkg::ST_OK;
    word          = '0;
    pend_wr       = '{we: 1'b0, addr: p_tail, data: req.item_word};
    undo_wr       = '{we: 1'b0, addr: u_top + IDX_ONE, data: pend_word};
    hist_wr       = '{we: 1'b0, addr: h_newest + IDX_ONE, data: pend_word};
    if (req_valid) begin
      case (req.req_type)
        wqh_pkg::REQ_ENQUEUE: begin
          if (p_count == wqh_pkg::FULL_COUNT) begin
            status = wqh_pkg::ST_FULL;
          end else begin
            pend_wr.we   = 1'b1;
            p_count_next = p_count + CNT_ONE;
          end
        end
        wqh_pkg::REQ_PROCESS: begin
          if (p_count == '0) begin
            status = wqh_pkg::ST_EMPTY;
          end else begin
            word          = pend_word;
            p_head_next   = p_head + IDX_ONE;
            p_count_next  = p_count - CNT_ONE;
            undo_wr.we    = 1'b1;
            u_top_next    = u_top + IDX_ONE;
            hist_wr.we    = 1'b1;
            h_newest_next = h_newest + IDX_ONE;
            if (u_count != wqh_pkg::FULL_COUNT) begin
              u_count_next = u_count + CNT_ONE;
            end
            if (h_count != wqh_pkg::FULL_COUNT) begin
              h_count_next = h_count + CNT_ONE;
            end
          end
        end
        wqh_pkg::REQ_UNDO: begin
          if (u_count == '0) begin
            status = wqh_pkg::ST_EMPTY;
          end else if (p_count == wqh_pkg::FULL_COUNT) begin
            status = wqh_pkg::ST_FULL;
          end else begin
            word         = undo_word;
            pend_wr.we   = 1'b1;
            pend_wr.data = undo_word;
            p_count_next = p_count + CNT_ONE;
            u_top_next   = u_top - IDX_ONE;
            u_count_next = u_count - CNT_ONE;
          end
        end
        wqh_pkg::REQ_CLEAR_HIST: begin
          if (h_count == '0) begin
            status = wqh_pkg::ST_EMPTY;
          end
          h_count_next = '0;
        end
        wqh_pkg::REQ_READ_PENDING: begin
          if (p_count == '0) begin
            status = wqh_pkg::ST_EMPTY;
          end else if (pos_ext >= p_count) begin
            status = wqh_pkg::ST_BADPOS;
          end else begin
            word = pend_word;
          end
        end
        wqh_pkg::REQ_READ_HIST: begin
          if (h_count == '0) begin
            status = wqh_pkg::ST_EMPTY;
          end else if (pos_ext >= h_count) begin
            status = wqh_pkg::ST_BADPOS;
          end else begin
            word = hist_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.status        = status;
    res.result_word   = word;
    res.pending_total = p_count_next;
    res.undo_total    = u_count_next;
    res.history_total = h_count_next;
  end

  always_ff @(posedge clk) begin
    pend_byp      <= pend_wr.we && (pend_wr.addr == pend_rd_addr);
    pend_byp_data <= pend_wr.data;
    undo_byp      <= undo_wr.we && (undo_wr.addr == undo_rd_addr);
    undo_byp_data <= undo_wr.data;
    hist_byp      <= hist_wr.we && (hist_wr.addr == hist_rd_addr);
    hist_byp_data <= hist_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_head   <= '0;
      p_count  <= '0;
      u_top    <= '0;
      u_count  <= '0;
      h_newest <= '0;
      h_count  <= '0;
    end else begin
      p_head   <= p_head_next;
      p_count  <= p_count_next;
      u_top    <= u_top_next;
      u_count  <= u_count_next;
      h_newest <= h_newest_next;
      h_count  <= h_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/work_queue_with_undo_and_history.sv
// Top level: request register, control, three ring stores and result register.
//
// Usage:
//   A request (type, word, position) is taken at a rising edge where start is
//   high and busy is low. busy is always low: a request may be issued in every
//   cycle, so the sustained rate is one request per clock.
//   Each request produces exactly one result. done is high for one cycle while
//   result holds status, the word read, processed or undone, and the three
//   occupancy counts after the request.
//   A request is registered, and its store words read, at the edge that takes
//   it; the control then decodes it and the result register captures its
//   result as done is set.
//   Back-to-back requests see each other's effects in order: store reads use
//   the pointers left by the request ahead, and a word written at the same
//   edge is forwarded.
//   The receiver cannot stall; results are never held or dropped.
//   Reset (rst, synchronous, active high) clears all pointers and counts and
//   drops any request in flight. Store contents are not cleared; the counts
//   keep reads away from entries never written.
`default_nettype none
module work_queue_with_undo_and_history (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire wqh_pkg::req_t request,
  output logic               done,
  output wqh_pkg::res_t      result
);

  logic          req_valid;
  wqh_pkg::req_t req;
  wqh_pkg::res_t res_next;

  logic [wqh_pkg::IDX_W-1:0]  pend_rd_addr, undo_rd_addr, hist_rd_addr;
  logic [wqh_pkg::WORD_W-1:0] pend_rd_data, undo_rd_data, hist_rd_data;
  wqh_pkg::store_wr_t         pend_wr, undo_wr, hist_wr;

  // every request completes in a single pass
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      req_valid <= start && !busy;
      done      <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    req    <= request;
    result <= res_next;
  end

  wqh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req          (req),
    .req_in       (request),
    .pend_rd_data (pend_rd_data),
    .undo_rd_data (undo_rd_data),
    .hist_rd_data (hist_rd_data),
    .pend_rd_addr (pend_rd_addr),
    .undo_rd_addr (undo_rd_addr),
    .hist_rd_addr (hist_rd_addr),
    .pend_wr      (pend_wr),
    .undo_wr      (undo_wr),
    .hist_wr      (hist_wr),
    .res          (res_next)
  );

  wqh_store #(
    .WIDTH (wqh_pkg::WORD_W),
    .DEPTH (wqh_pkg::DEPTH)
  ) u_pend (
    .clk     (clk),
    .we      (pend_wr.we),
    .wr_addr (pend_wr.addr),
    .wr_data (pend_wr.data),
    .rd_addr (pend_rd_addr),
    .rd_data (pend_rd_data)
  );

  wqh_store #(
    .WIDTH (wqh_pkg::WORD_W),
    .DEPTH (wqh_pkg::DEPTH)
  ) u_undo (
    .clk     (clk),
    .we      (undo_wr.we),
    .wr_addr (undo_wr.addr),
    .wr_data (undo_wr.data),
    .rd_addr (undo_rd_addr),
    .rd_data (undo_rd_data)
  );

  wqh_store #(
    .WIDTH (wqh_pkg::WORD_W),
    .DEPTH (wqh_pkg::DEPTH)
  ) u_hist (
    .clk     (clk),
    .we      (hist_wr.we),
    .wr_addr (hist_wr.addr),
    .wr_data (hist_wr.data),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

endmodule
`default_nettype wire

FILE: tb/sv/wqh_checker.sv
// Checker: predicts queue, undo and history behavior and compares each result.
`timescale 1ns / 1ps
module wqh_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire wqh_pkg::req_t request,
  input  wire logic          done,
  input  wire wqh_pkg::res_t result,
  output int                 fail_count,
  output int                 outstanding
);

  logic [wqh_pkg::WORD_W-1:0] pend_ring [wqh_pkg::DEPTH];
  logic [wqh_pkg::WORD_W-1:0] undo_ring [wqh_pkg::DEPTH];
  logic [wqh_pkg::WORD_W-1:0] hist_ring [wqh_pkg::DEPTH];
  logic [wqh_pkg::IDX_W-1:0]  pend_head, undo_top, hist_newest;
  logic [wqh_pkg::CNT_W-1:0]  pend_cnt, undo_cnt, hist_cnt;

  wqh_pkg::res_t expected_results[$];

  function automatic wqh_pkg::res_t apply_request(wqh_pkg::req_t r);
    wqh_pkg::res_t              res;
    logic [wqh_pkg::IDX_W-1:0]  idx;
    logic [wqh_pkg::WORD_W-1:0] word;
    res = '0;
    res.status = wqh_pkg::ST_OK;
    word = '0;
    case (r.req_type)
      wqh_pkg::REQ_ENQUEUE: begin
        if (pend_cnt == wqh_pkg::FULL_COUNT) begin
          res.status = wqh_pkg::ST_FULL;
        end else begin
          idx = wqh_pkg::IDX_W'(pend_head + pend_cnt);
          pend_ring[idx] = r.item_word;
          pend_cnt = pend_cnt + 1'b1;
        end
      end
      wqh_pkg::REQ_PROCESS: begin
        if (pend_cnt == '0) begin
          res.status = wqh_pkg::ST_EMPTY;
        end else begin
          word = pend_ring[pend_head];
          pend_head = pend_head + 1'b1;
          pend_cnt = pend_cnt - 1'b1;
          undo_top = undo_top + 1'b1;
          undo_ring[undo_top] = word;
          if (undo_cnt != wqh_pkg::FULL_COUNT) undo_cnt = undo_cnt + 1'b1;
          hist_newest = hist_newest + 1'b1;
          hist_ring[hist_newest] = word;
          if (hist_cnt != wqh_pkg::FULL_COUNT) hist_cnt = hist_cnt + 1'b1;
        end
      end
      wqh_pkg::REQ_UNDO: begin
        if (undo_cnt == '0) begin
          res.status = wqh_pkg::ST_EMPTY;
        end else if (pend_cnt == wqh_pkg::FULL_COUNT) begin
          res.status = wqh_pkg::ST_FULL;
        end else begin
          word = undo_ring[undo_top];
          idx = wqh_pkg::IDX_W'(pend_head + pend_cnt);
          pend_ring[idx] = word;
          pend_cnt = pend_cnt + 1'b1;
          undo_top = undo_top - 1'b1;
          undo_cnt = undo_cnt - 1'b1;
        end
      end
      wqh_pkg::REQ_CLEAR_HIST: begin
        if (hist_cnt == '0) res.status = wqh_pkg::ST_EMPTY;
        hist_cnt = '0;
      end
      wqh_pkg::REQ_READ_PENDING: begin
        if (pend_cnt == '0) begin
          res.status = wqh_pkg::ST_EMPTY;
        end else if (wqh_pkg::CNT_W'(r.position) >= pend_cnt) begin
          res.status = wqh_pkg::ST_BADPOS;
        end else begin
          idx = pend_head + r.position;
          word = pend_ring[idx];
        end
      end
      wqh_pkg::REQ_READ_HIST: begin
        if (hist_cnt == '0) begin
          res.status = wqh_pkg::ST_EMPTY;
        end else if (wqh_pkg::CNT_W'(r.position) >= hist_cnt) begin
          res.status = wqh_pkg::ST_BADPOS;
        end else begin
          idx = hist_newest - r.position;
          word = hist_ring[idx];
        end
      end
      default: ;
    endcase
    res.result_word   = word;
    res.pending_total = pend_cnt;
    res.undo_total    = undo_cnt;
    res.history_total = hist_cnt;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    wqh_pkg::res_t exp_res;
    if (rst) begin
      pend_head = '0;
      undo_top = '0;
      hist_newest = '0;
      pend_cnt = '0;
      undo_cnt = '0;
      hist_cnt = '0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result %h", $realtime, result);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (result.status !== exp_res.status ||
              result.result_word !== exp_res.result_word ||
              result.pending_total !== exp_res.pending_total ||
              result.undo_total !== exp_res.undo_total ||
              result.history_total !== exp_res.history_total) begin
            if (fail_count < 10)
              $display({"%0t: mismatch exp st=%0d w=%h p=%0d u=%0d h=%0d,",
                        " got st=%0d w=%h p=%0d u=%0d h=%0d"},
                       $realtime, exp_res.status, exp_res.result_word,
                       exp_res.pending_total, exp_res.undo_total, exp_res.history_total,
                       result.status, result.result_word,
                       result.pending_total, result.undo_total, result.history_total);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(request));
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: clock, reset, request stimulus and final verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL    = 200;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_UNDO, MODE_MIXED} traffic_mode_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  wqh_pkg::req_t request;
  logic          done;
  wqh_pkg::res_t result;
  int            fail_count;
  int            outstanding;
  int            idle_pct;

  work_queue_with_undo_and_history dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  wqh_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("work_queue_with_undo_and_history test failed");
    $finish;
  end

  function automatic wqh_pkg::req_t make_req(logic [2:0] code,
                                             logic [wqh_pkg::WORD_W-1:0] word,
                                             logic [wqh_pkg::IDX_W-1:0] pos);
    wqh_pkg::req_t r;
    r.req_type = code;
    r.item_word = word;
    r.position = pos;
    return r;
  endfunction

  task automatic send_req(wqh_pkg::req_t r);
    int gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 19);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [2:0] pick_code(traffic_mode_t mode);
    int roll;
    int enq_w, proc_w, undo_w, rdp_w, rdh_w, clr_w;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        enq_w = 55; proc_w = 12; undo_w = 6; rdp_w = 15; rdh_w = 8; clr_w = 1;
      end
      MODE_DRAIN: begin
        enq_w = 15; proc_w = 45; undo_w = 5; rdp_w = 15; rdh_w = 15; clr_w = 2;
      end
      MODE_UNDO: begin
        enq_w = 20; proc_w = 25; undo_w = 35; rdp_w = 10; rdh_w = 7; clr_w = 1;
      end
      default: begin
        enq_w = 25; proc_w = 25; undo_w = 15; rdp_w = 15; rdh_w = 13; clr_w = 3;
      end
    endcase
    if (roll < enq_w) return wqh_pkg::REQ_ENQUEUE;
    roll -= enq_w;
    if (roll < proc_w) return wqh_pkg::REQ_PROCESS;
    roll -= proc_w;
    if (roll < undo_w) return wqh_pkg::REQ_UNDO;
    roll -= undo_w;
    if (roll < rdp_w) return wqh_pkg::REQ_READ_PENDING;
    roll -= rdp_w;
    if (roll < rdh_w) return wqh_pkg::REQ_READ_HIST;
    roll -= rdh_w;
    if (roll < clr_w) return wqh_pkg::REQ_CLEAR_HIST;
    return $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
  endfunction

  function automatic logic [wqh_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    traffic_mode_t              mode;
    logic [wqh_pkg::WORD_W-1:0] word;
    logic [wqh_pkg::IDX_W-1:0]  pos;
    start <= 1'b0;
    request <= '0;
    rst <= 1'b1;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty stores and spare codes
    send_req(make_req(wqh_pkg::REQ_PROCESS, '0, '0));
    send_req(make_req(wqh_pkg::REQ_UNDO, '0, '0));
    send_req(make_req(wqh_pkg::REQ_CLEAR_HIST, '0, '0));
    send_req(make_req(wqh_pkg::REQ_READ_PENDING, '1, '0));
    send_req(make_req(wqh_pkg::REQ_READ_HIST, '0, '1));
    send_req(make_req(REQ_SPARE_A, '1, '1));
    send_req(make_req(REQ_SPARE_B, '0, '0));
    // fill the FIFO, then overflow it
    for (int i = 0; i < wqh_pkg::DEPTH; i++) begin
      case (i)
        0:       word = '0;
        1:       word = '1;
        2:       word = 32'h8000_0000;
        3:       word = 32'h0000_0001;
        4:       word = 32'hAAAA_AAAA;
        5:       word = 32'h5555_5555;
        default: word = $urandom;
      endcase
      send_req(make_req(wqh_pkg::REQ_ENQUEUE, word, wqh_pkg::IDX_W'(i)));
    end
    send_req(make_req(wqh_pkg::REQ_ENQUEUE, 32'h1234_5678, '0));
    send_req(make_req(wqh_pkg::REQ_READ_PENDING, '0, '1));
    send_req(make_req(wqh_pkg::REQ_PROCESS, '0, '0));
    send_req(make_req(wqh_pkg::REQ_READ_PENDING, '0, '1));
    send_req(make_req(wqh_pkg::REQ_ENQUEUE, 32'hDEAD_BEEF, '0));
    send_req(make_req(wqh_pkg::REQ_UNDO, '0, '0));
    send_req(make_req(wqh_pkg::REQ_READ_HIST, '0, '0));
    send_req(make_req(wqh_pkg::REQ_READ_HIST, '0, wqh_pkg::IDX_W'(1)));
    send_req(make_req(wqh_pkg::REQ_CLEAR_HIST, '0, '0));

    mode = MODE_MIXED;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        mode = traffic_mode_t'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_TAIL) idle_pct = 0;
      pos = $urandom_range(0, 1) ? wqh_pkg::IDX_W'($urandom_range(0, 15))
                                 : wqh_pkg::IDX_W'($urandom_range(0, 4));
      send_req(make_req(pick_code(mode), pick_word(), pos));
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("work_queue_with_undo_and_history test passed");
    end else begin
      $display("work_queue_with_undo_and_history test failed");
    end
    $finish;
  end

endmodule
